>>> rtl/quaternion_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QAU_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("latency assertion failed");
`else
`define QAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define QAU_ASSERT_DELAY(label, clk, rst_n, ante, n, cons)
`endif
`endif

>>> rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Opcodes, CORDIC constants and shared widths.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_W = 34;
    localparam int OP_W = 18;

    localparam logic signed [CORDIC_W-1:0] K_Q30 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef enum logic [2:0] {
        CMD_MUL   = 3'd0,
        CMD_VEC   = 3'd1,
        CMD_ROT   = 3'd2,
        CMD_CONJ  = 3'd3,
        CMD_AXIS  = 3'd4,
        CMD_EULER = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
    } item_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314856;
            1:       v = 32'd497837829;
            2:       v = 32'd263043836;
            3:       v = 32'd133525158;
            4:       v = 32'd67021686;
            5:       v = 32'd33543515;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194282;
            9:       v = 32'd2097149;
            10:      v = 32'd1048575;
            11:      v = 32'd524287;
            12:      v = 32'd262143;
            13:      v = 32'd131071;
            14:      v = 32'd65535;
            15:      v = 32'd32767;
            16:      v = 32'd16383;
            17:      v = 32'd8191;
            18:      v = 32'd4095;
            19:      v = 32'd2047;
            20:      v = 32'd1023;
            21:      v = 32'd511;
            22:      v = 32'd255;
            23:      v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Hamilton products, vector rotation, conjugate, angle-axis and Euler
// conversion in Q2.14 fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// A command transfer happens at a rising edge with start high and busy low.
// The unit never stalls, so busy is always low and a command may be issued
// in every cycle. Each command yields one result, shown on r_x, r_y, r_z,
// r_w and overflow for exactly one cycle while done is high.
// The pipeline holds one range reduction stage and one stage per CORDIC
// step, one stage for the axis products, two stages for each of the two
// chained Hamilton products and one saturation stage, for every opcode.
// Throughput is one command per cycle, set by the fully pipelined CORDIC
// lanes and product arrays.
// Results leave in the order that commands were issued. Reset clears the
// valid bits of the pipeline, so no result appears until a command arrives.
// The receiver cannot stall; results must be taken when done is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_arithmetic_unit_assert.svh"

module quaternion_arithmetic_unit #(
    parameter int CORDIC_STEPS = qau_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [15:0] a_x,
    input  wire logic signed [15:0] a_y,
    input  wire logic signed [15:0] a_z,
    input  wire logic signed [15:0] a_w,
    input  wire logic signed [15:0] b_x,
    input  wire logic signed [15:0] b_y,
    input  wire logic signed [15:0] b_z,
    input  wire logic signed [15:0] b_w,
    output logic                    done,
    output logic signed [15:0]      r_x,
    output logic signed [15:0]      r_y,
    output logic signed [15:0]      r_z,
    output logic signed [15:0]      r_w,
    output logic                    overflow
);

    localparam int CW = qau_pkg::CORDIC_W;
    localparam int QW = qau_pkg::OP_W;
    localparam int M1W = 2 * QW + 2 - 14;
    localparam int M2W = M1W + QW + 2 - 14;
    localparam int LAT = CORDIC_STEPS + 7;

    localparam logic signed [QW-1:0] ONE = QW'(16384);
    localparam logic signed [M2W-1:0] SAT_HI = M2W'(32767);
    localparam logic signed [M2W-1:0] SAT_LO = M2W'(-32768);

    qau_pkg::item_t      side_reg [0:CORDIC_STEPS];
    logic                vld_reg [0:CORDIC_STEPS];
    qau_pkg::item_t      item_in;

    logic signed [15:0]  angle0;
    logic signed [CW-1:0] sin_q [3];
    logic signed [CW-1:0] cos_q [3];

    logic signed [QW-1:0] l_next [4];
    logic signed [QW-1:0] rr_next [4];
    logic signed [QW-1:0] b2_next [4];
    logic signed [QW-1:0] l_reg [4];
    logic signed [QW-1:0] rr_reg [4];
    logic signed [QW-1:0] b2_reg [4];
    logic signed [QW-1:0] b2_d1_reg [4];
    logic signed [QW-1:0] b2_d2_reg [4];
    logic [2:0]           cmd_ax_reg;
    logic [2:0]           cmd_d_reg [4];
    logic                 vld_ax_reg;
    logic                 vld_d_reg [4];

    logic signed [M1W-1:0] m1 [4];
    logic signed [M2W-1:0] m2 [4];

    logic signed [15:0]   res_next [4];
    logic                 ov_next;
    logic signed [15:0]   res_reg [4];
    logic                 ov_reg;
    logic                 done_reg;

    assign busy = 1'b0;

    always_comb
    begin
        item_in.cmd = cmd;
        item_in.a = {a_w, a_z, a_y, a_x};
        item_in.b = {b_w, b_z, b_y, b_x};
        angle0 = (cmd == qau_pkg::CMD_AXIS) ? b_w : b_x;
    end

    qau_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_0 (
        .clk(clk), .angle(angle0), .sin_q30(sin_q[0]), .cos_q30(cos_q[0])
    );
    qau_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_1 (
        .clk(clk), .angle(b_y), .sin_q30(sin_q[1]), .cos_q30(cos_q[1])
    );
    qau_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_2 (
        .clk(clk), .angle(b_z), .sin_q30(sin_q[2]), .cos_q30(cos_q[2])
    );

    always_ff @(posedge clk)
    begin
        side_reg[0] <= item_in;
        for (int i = 1; i <= CORDIC_STEPS; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            vld_ax_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                vld_d_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            vld_ax_reg <= vld_reg[CORDIC_STEPS];
            vld_d_reg[0] <= vld_ax_reg;
            for (int i = 1; i < 4; i++)
            begin
                vld_d_reg[i] <= vld_d_reg[i-1];
            end
            done_reg <= vld_d_reg[3];
        end
    end

    // Axis stage: turn the sine and cosine lanes into quaternions and pick
    // the operands of both chained products.
    always_comb
    begin
        qau_pkg::item_t      it;
        logic signed [15:0]  ax [3];
        logic signed [47:0]  prod;
        logic signed [CW-1:0] t;
        logic signed [QW-1:0] q0 [4];
        logic signed [QW-1:0] q1 [4];
        logic signed [QW-1:0] q2 [4];
        logic signed [QW-1:0] av [4];
        logic signed [QW-1:0] ac [4];
        logic signed [QW-1:0] bv [4];
        logic signed [QW-1:0] id [4];

        it = side_reg[CORDIC_STEPS];
        if (it.cmd == qau_pkg::CMD_AXIS)
        begin
            ax[0] = $signed(it.b[0]);
            ax[1] = $signed(it.b[1]);
            ax[2] = $signed(it.b[2]);
        end
        else
        begin
            ax[0] = 16'sd16384;
            ax[1] = 16'sd0;
            ax[2] = 16'sd0;
        end
        for (int k = 0; k < 3; k++)
        begin
            prod = 48'(ax[k]) * 48'($signed(sin_q[0][31:0]));
            prod = prod + (48'sd1 <<< 29);
            q0[k] = prod[47:30];
        end
        t = cos_q[0] + CW'(32768);
        q0[3] = t[CW-1:16];

        q1[0] = '0;
        t = sin_q[1] + CW'(32768);
        q1[1] = t[CW-1:16];
        q1[2] = '0;
        t = cos_q[1] + CW'(32768);
        q1[3] = t[CW-1:16];

        q2[0] = '0;
        q2[1] = '0;
        t = sin_q[2] + CW'(32768);
        q2[2] = t[CW-1:16];
        t = cos_q[2] + CW'(32768);
        q2[3] = t[CW-1:16];

        for (int k = 0; k < 4; k++)
        begin
            av[k] = QW'($signed(it.a[k]));
            bv[k] = QW'($signed(it.b[k]));
            ac[k] = (k == 3) ? av[k] : -av[k];
            id[k] = (k == 3) ? ONE : '0;
        end

        l_next = id;
        rr_next = id;
        b2_next = id;
        for (int k = 0; k < 4; k++)
        begin
            l_next[k] = '0;
        end
        case (it.cmd)
            qau_pkg::CMD_MUL:
            begin
                l_next = av;
                rr_next = bv;
            end
            qau_pkg::CMD_VEC:
            begin
                l_next = av;
                rr_next = bv;
                rr_next[3] = '0;
            end
            qau_pkg::CMD_ROT:
            begin
                l_next = av;
                rr_next = bv;
                rr_next[3] = '0;
                b2_next = ac;
            end
            qau_pkg::CMD_CONJ:
            begin
                l_next = ac;
            end
            qau_pkg::CMD_AXIS:
            begin
                l_next = q0;
            end
            qau_pkg::CMD_EULER:
            begin
                l_next = q0;
                rr_next = q1;
                b2_next = q2;
            end
            default:
            begin
                l_next = id;
                l_next[3] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        rr_reg <= rr_next;
        b2_reg <= b2_next;
        b2_d1_reg <= b2_reg;
        b2_d2_reg <= b2_d1_reg;
        cmd_ax_reg <= side_reg[CORDIC_STEPS].cmd;
        cmd_d_reg[0] <= cmd_ax_reg;
        for (int i = 1; i < 4; i++)
        begin
            cmd_d_reg[i] <= cmd_d_reg[i-1];
        end
    end

    qau_qmul #(.AW(QW), .BW(QW)) u_qmul_first (
        .clk(clk), .a(l_reg), .b(rr_reg), .r(m1)
    );

    qau_qmul #(.AW(M1W), .BW(QW)) u_qmul_second (
        .clk(clk), .a(m1), .b(b2_d2_reg), .r(m2)
    );

    always_comb
    begin
        ov_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (m2[k] > SAT_HI)
            begin
                res_next[k] = 16'sd32767;
                if ((k != 3) || (cmd_d_reg[3] != qau_pkg::CMD_ROT))
                begin
                    ov_next = 1'b1;
                end
            end
            else if (m2[k] < SAT_LO)
            begin
                res_next[k] = 16'sh8000;
                if ((k != 3) || (cmd_d_reg[3] != qau_pkg::CMD_ROT))
                begin
                    ov_next = 1'b1;
                end
            end
            else
            begin
                res_next[k] = m2[k][15:0];
            end
        end
        if (cmd_d_reg[3] == qau_pkg::CMD_ROT)
        begin
            res_next[3] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        ov_reg <= ov_next;
    end

    assign done = done_reg;
    assign r_x = res_reg[0];
    assign r_y = res_reg[1];
    assign r_z = res_reg[2];
    assign r_w = res_reg[3];
    assign overflow = ov_reg;

    `QAU_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LAT, done)
    `QAU_ASSERT_IMPLY(a_never_busy, clk, rst_n, start, !busy)
    `QAU_ASSERT_IMPLY(a_ovf_at_rail, clk, rst_n, done && overflow, (r_x == 16'sh7fff) || (r_x == 16'sh8000) || (r_y == 16'sh7fff) || (r_y == 16'sh8000) || (r_z == 16'sh7fff) || (r_z == 16'sh8000) || (r_w == 16'sh7fff) || (r_w == 16'sh8000))

endmodule

`default_nettype wire

>>> rtl/qau_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined half-angle CORDIC
// Range reduction stage followed by one register stage per rotation step.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_cordic #(
    parameter int STEPS = qau_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic signed [15:0]                   angle,
    output logic signed [qau_pkg::CORDIC_W-1:0]       sin_q30,
    output logic signed [qau_pkg::CORDIC_W-1:0]       cos_q30
);

    localparam int W = qau_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [0:STEPS];
    logic signed [W-1:0] y_reg [0:STEPS];
    logic signed [W-1:0] z_reg [0:STEPS];
    logic                neg_reg [0:STEPS];

    logic signed [W-1:0] z_in;
    logic signed [W-1:0] z_next;
    logic                neg_next;

    always_comb
    begin
        z_in = W'(angle) <<< 17;
        z_next = z_in;
        neg_next = 1'b0;
        if (z_in > qau_pkg::HALF_PI_Q30)
        begin
            z_next = z_in - qau_pkg::PI_Q30;
            neg_next = 1'b1;
        end
        else if (z_in < -qau_pkg::HALF_PI_Q30)
        begin
            z_next = z_in + qau_pkg::PI_Q30;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= qau_pkg::K_Q30;
        y_reg[0] <= '0;
        z_reg[0] <= z_next;
        neg_reg[0] <= neg_next;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [W-1:0] ATAN = W'(qau_pkg::atan_q30(i));
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][W-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            neg_reg[i+1] <= neg_reg[i];
        end
    end

    assign sin_q30 = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
    assign cos_q30 = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];

endmodule

`default_nettype wire

>>> rtl/qau_qmul.sv
// ----------------------------------------------------------------------------
// Two-stage Hamilton product
// Sixteen registered products, then signed sums rounded to Q14.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_qmul #(
    parameter int AW = 18,
    parameter int BW = 18,
    localparam int PW = AW + BW,
    localparam int SW = PW + 2,
    localparam int RW = SW - 14
) (
    input  wire logic                 clk,
    input  wire logic signed [AW-1:0] a [4],
    input  wire logic signed [BW-1:0] b [4],
    output logic signed [RW-1:0]      r [4]
);

    logic signed [PW-1:0] p_reg [16];
    logic signed [RW-1:0] r_reg [4];
    logic signed [SW-1:0] s [4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p_reg[i*4+j] <= PW'(a[i]) * PW'(b[j]);
            end
        end
    end

    always_comb
    begin
        s[0] = SW'(p_reg[3]) + SW'(p_reg[12]) + SW'(p_reg[6]) - SW'(p_reg[9]);
        s[1] = SW'(p_reg[7]) + SW'(p_reg[13]) + SW'(p_reg[8]) - SW'(p_reg[2]);
        s[2] = SW'(p_reg[11]) + SW'(p_reg[14]) + SW'(p_reg[1]) - SW'(p_reg[4]);
        s[3] = SW'(p_reg[15]) - SW'(p_reg[0]) - SW'(p_reg[5]) - SW'(p_reg[10]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            r_reg[k] <= RW'((s[k] + SW'(8192)) >>> 14);
        end
    end

    assign r = r_reg;

endmodule

`default_nettype wire

>>> test/quaternion_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit checker
// Watches command and result transfers, predicts each result from the
// command operands in fixed point, and compares field by field in order.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         cmd,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] a_w,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] b_w,
    input  logic               done,
    input  logic signed [15:0] r_x,
    input  logic signed [15:0] r_y,
    input  logic signed [15:0] r_z,
    input  logic signed [15:0] r_w,
    input  logic               overflow,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] w;
        logic        ov;
    } quat_result_t;

    typedef longint quat4_t [4];

    localparam longint K_GAIN = 64'sd652032874;
    localparam longint PI_FX = 64'sd3373259426;
    localparam longint HALF_PI_FX = 64'sd1686629713;
    localparam int STEPS = qau_pkg::CORDIC_STEPS_DEF;

    quat_result_t expected_results[$];

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic quat4_t hamilton(input quat4_t a, input quat4_t b);
        quat4_t r;
        r[0] = round_shift(a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1], 14);
        r[1] = round_shift(a[1]*b[3] + a[3]*b[1] + a[2]*b[0] - a[0]*b[2], 14);
        r[2] = round_shift(a[2]*b[3] + a[3]*b[2] + a[0]*b[1] - a[1]*b[0], 14);
        r[3] = round_shift(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2], 14);
        return r;
    endfunction

    function automatic longint atan_step(input int i);
        return longint'(qau_pkg::atan_q30(i));
    endfunction

    function automatic quat4_t angle_axis(input longint ang, input longint ax,
                                          input longint ay, input longint az);
        longint z, x, y, nx;
        bit neg;
        quat4_t r;
        z = ang * 131072;
        x = K_GAIN;
        y = 0;
        neg = 1'b0;
        if (z > HALF_PI_FX)
        begin
            z -= PI_FX;
            neg = 1'b1;
        end
        else if (z < -HALF_PI_FX)
        begin
            z += PI_FX;
            neg = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step(i);
            end
            x = nx;
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        r[0] = round_shift(ax * y, 30);
        r[1] = round_shift(ay * y, 30);
        r[2] = round_shift(az * y, 30);
        r[3] = round_shift(x, 16);
        return r;
    endfunction

    function automatic quat_result_t predict_quat(input logic [2:0] op,
                                                  input quat4_t a, input quat4_t b);
        quat4_t r, t, u, q;
        quat_result_t res;
        int n;
        r = '{0, 0, 0, 0};
        n = 4;
        case (op)
            qau_pkg::CMD_MUL: r = hamilton(a, b);
            qau_pkg::CMD_VEC:
            begin
                b[3] = 0;
                r = hamilton(a, b);
            end
            qau_pkg::CMD_ROT:
            begin
                b[3] = 0;
                t = hamilton(a, b);
                u = '{-a[0], -a[1], -a[2], a[3]};
                r = hamilton(t, u);
                r[3] = 0;
                n = 3;
            end
            qau_pkg::CMD_CONJ: r = '{-a[0], -a[1], -a[2], a[3]};
            qau_pkg::CMD_AXIS: r = angle_axis(b[3], b[0], b[1], b[2]);
            qau_pkg::CMD_EULER:
            begin
                t = angle_axis(b[0], 16384, 0, 0);
                u = angle_axis(b[1], 0, 16384, 0);
                q = hamilton(t, u);
                t = angle_axis(b[2], 0, 0, 16384);
                r = hamilton(q, t);
            end
            default: ;
        endcase
        res.ov = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            if (r[k] > 32767)
            begin
                r[k] = 32767;
                res.ov = 1'b1;
            end
            else if (r[k] < -32768)
            begin
                r[k] = -32768;
                res.ov = 1'b1;
            end
        end
        res.x = r[0][15:0];
        res.y = r[1][15:0];
        res.z = r[2][15:0];
        res.w = r[3][15:0];
        return res;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        quat_result_t got, exp_res;
        quat4_t qa, qb;
        if (!rst_n)
            fail_count <= 0;
        else
        begin
            if (done)
            begin
                got = '{r_x, r_y, r_z, r_w, overflow};
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch expected %h %h %h %h %b got %h %h %h %h %b",
                                     exp_res.x, exp_res.y, exp_res.z, exp_res.w, exp_res.ov,
                                     got.x, got.y, got.z, got.w, got.ov);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                qa = '{a_x, a_y, a_z, a_w};
                qb = '{b_x, b_y, b_z, b_w};
                expected_results.push_back(predict_quat(cmd, qa, qb));
            end
        end
    end
endmodule

>>> test/quaternion_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Drives directed corner commands and random commands with random gaps,
// and gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1880;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] cmd = '0;
    logic signed [15:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
    logic signed [15:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
    logic busy, done, overflow;
    logic signed [15:0] r_x, r_y, r_z, r_w;
    int fail_count, pending, idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quaternion_arithmetic_unit u_top (.*);
    quaternion_arithmetic_unit_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic issue_command(input logic [2:0] op, input logic [15:0] ax,
                                 input logic [15:0] ay, input logic [15:0] az,
                                 input logic [15:0] aw, input logic [15:0] bx,
                                 input logic [15:0] by, input logic [15:0] bz,
                                 input logic [15:0] bw);
        start <= 1'b1;
        cmd <= op;
        a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
        b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic random_command(input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        issue_command(3'($urandom_range(0, 7)), pick_value(), pick_value(),
                      pick_value(), pick_value(), pick_value(), pick_value(),
                      pick_value(), pick_value());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        issue_command(qau_pkg::CMD_MUL, 16'h4000, 16'h0, 16'h0, 16'h4000,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        issue_command(qau_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000, 16'h8000);
        issue_command(qau_pkg::CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                      16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        issue_command(qau_pkg::CMD_VEC, 16'h0, 16'h0, 16'h0, 16'h4000,
                      16'h4000, 16'hc000, 16'h2000, 16'h7fff);
        issue_command(qau_pkg::CMD_ROT, 16'h0, 16'h0, 16'h2d41, 16'h2d41,
                      16'h4000, 16'h0, 16'h0, 16'h1234);
        issue_command(qau_pkg::CMD_ROT, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h0);
        issue_command(qau_pkg::CMD_CONJ, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h0, 16'h0, 16'h0, 16'h0);
        issue_command(qau_pkg::CMD_CONJ, 16'h7fff, 16'h0001, 16'hffff, 16'h7fff,
                      16'h0, 16'h0, 16'h0, 16'h0);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h4000, 16'h0, 16'h0, 16'h3244);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h8000, 16'h8000, 16'h8000, 16'h8000);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h4000, 16'h4000, 16'h0, 16'h1922);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h4000, 16'h4000, 16'h0, 16'h1921);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h4000, 16'h0, 16'h4000, 16'he6de);
        issue_command(qau_pkg::CMD_AXIS, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h4000, 16'h0, 16'h4000, 16'he6df);
        issue_command(qau_pkg::CMD_EULER, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h0, 16'h0, 16'h0, 16'h0);
        issue_command(qau_pkg::CMD_EULER, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h0);
        issue_command(qau_pkg::CMD_EULER, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h1922, 16'he6de, 16'h0c91, 16'h0);
        issue_command(3'd6, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                      16'h1, 16'h2, 16'h3, 16'h4);
        issue_command(3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h1, 16'h2, 16'h3, 16'h4);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            random_command(i < RANDOM_ITEMS - 200);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
